>>> sv/rcpe_pkg.sv
// Shared types, constants and code tables for the rolling-code packet encoder.
// No dependencies; every other file imports this package.
package rcpe_pkg;

  localparam int CNT_W       = 28;
  localparam int BTN_W       = 8;
  localparam int SER_W       = 32;
  localparam int PKT_W       = 46;
  localparam int WORD_W      = 10;
  localparam int FIX_W       = 2 * WORD_W;
  localparam int NUM_DIGITS  = 18;
  localparam int HALF_DIGITS = NUM_DIGITS / 2;
  localparam int DIG_PER_STG = 3;
  localparam int NUM_STG     = NUM_DIGITS / DIG_PER_STG;
  localparam int STG_W       = $clog2(NUM_STG);
  localparam int DIG_IDX_W   = $clog2(NUM_DIGITS);

  localparam logic [3:0] HDR_NIB     = 4'hF;
  localparam logic       FLAG_FIRST  = 1'b0;
  localparam logic       FLAG_SECOND = 1'b1;

  // powers of three, index = digit weight
  localparam logic [CNT_W-1:0] POW3 [NUM_DIGITS] = '{
    28'd1,        28'd3,        28'd9,        28'd27,
    28'd81,       28'd243,      28'd729,      28'd2187,
    28'd6561,     28'd19683,    28'd59049,    28'd177147,
    28'd531441,   28'd1594323,  28'd4782969,  28'd14348907,
    28'd43046721, 28'd129140163
  };

  typedef logic [NUM_DIGITS-1:0][1:0]  digits_t;
  typedef logic [HALF_DIGITS-1:0][1:0] half_dig_t;
  typedef logic [2:0][1:0]             perm_t;

  // conversion state carried down the pipe
  typedef struct packed {
    logic [CNT_W-1:0] rem;
    digits_t          digits;
    logic [BTN_W-1:0] button;
    logic [SER_W-1:0] serial;
  } stage_t;

  // source word index for output words 0..2, per order code
  function automatic perm_t perm_sel(input logic [3:0] ord);
    perm_t p;
    case (ord)
      4'd0:    p = '{2'd1, 2'd2, 2'd0};
      4'd1:    p = '{2'd1, 2'd0, 2'd2};
      4'd4:    p = '{2'd0, 2'd2, 2'd1};
      4'd5:    p = '{2'd2, 2'd0, 2'd1};
      4'd6:    p = '{2'd0, 2'd1, 2'd2};
      4'd8:    p = '{2'd0, 2'd2, 2'd1};
      4'd9:    p = '{2'd0, 2'd1, 2'd2};
      default: p = '{2'd2, 2'd1, 2'd0};
    endcase
    return p;
  endfunction

  // bit w set: word w is complemented
  function automatic logic [2:0] inv_sel(input logic [3:0] inv);
    logic [2:0] m;
    case (inv)
      4'd0:    m = 3'd3;
      4'd1:    m = 3'd2;
      4'd2:    m = 3'd4;
      4'd4:    m = 3'd7;
      4'd5:    m = 3'd5;
      4'd6:    m = 3'd6;
      4'd8:    m = 3'd1;
      4'd10:   m = 3'd5;
      default: m = 3'd0;
    endcase
    return m;
  endfunction

endpackage

>>> sv/rcpe_if.sv
// Valid/ready channel interfaces for the encoder's input and result words.
// Depends on rcpe_pkg for field widths.
interface rcpe_in_if import rcpe_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] counter_value;
  logic [BTN_W-1:0] button_code;
  logic [SER_W-1:0] serial_number;

  modport source (output valid, counter_value, button_code, serial_number, input ready);
  modport sink   (input valid, counter_value, button_code, serial_number, output ready);
endinterface

interface rcpe_out_if import rcpe_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PKT_W-1:0] first_packet;
  logic [PKT_W-1:0] second_packet;

  modport source (output valid, first_packet, second_packet, input ready);
  modport sink   (input valid, first_packet, second_packet, output ready);
endinterface

>>> sv/rcpe_digit_stage.sv
// One pipeline stage of the base-3 conversion: three digits by compare/subtract.
// Depends on rcpe_pkg; instantiated by rolling_code_packet_encoder.
module rcpe_digit_stage import rcpe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [STG_W-1:0] stage_idx,
  input  logic             in_valid,
  output logic             in_ready,
  input  stage_t           in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output stage_t           out_data
);

  logic   valid_r;
  stage_t data_r;
  stage_t data_nxt;

  always_comb begin
    logic [CNT_W-1:0] rem;
    logic [CNT_W:0]   p1;
    logic [CNT_W:0]   p2;
    logic [1:0]       dig;
    data_nxt = in_data;
    rem      = in_data.rem;
    for (int t = 0; t < DIG_PER_STG; t++) begin
      p1 = {1'b0, POW3[DIG_IDX_W'(NUM_DIGITS - 1 - DIG_PER_STG * int'(stage_idx) - t)]};
      p2 = {p1[CNT_W-1:0], 1'b0};
      if ({1'b0, rem} >= p2) begin
        dig = 2'd2;
        rem = CNT_W'({1'b0, rem} - p2);
      end else if ({1'b0, rem} >= p1) begin
        dig = 2'd1;
        rem = CNT_W'({1'b0, rem} - p1);
      end else begin
        dig = 2'd0;
      end
      data_nxt.digits[DIG_IDX_W'(DIG_PER_STG * int'(stage_idx) + t)] = dig;
    end
    data_nxt.rem = rem;
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

>>> sv/rcpe_half_builder.sv
// Builds one 46-bit packet from nine digits of a half and its 20 fixed bits.
// Depends on rcpe_pkg (permute and invert tables); used by the top level.
module rcpe_half_builder import rcpe_pkg::*; (
  input  half_dig_t        dig,
  input  logic [FIX_W-1:0] fixed_data,
  input  logic             packet_flag,
  output logic [PKT_W-1:0] packet
);

  logic [3:0]           ord;
  logic [3:0]           inv;
  logic [WORD_W-1:0]    src [3];
  logic [WORD_W-1:0]    w [3];
  perm_t                perm;
  logic [2:0]           inv_mask;
  logic [3*WORD_W-1:0]  data;

  assign ord      = {dig[0], dig[1]};
  assign inv      = {dig[2], dig[3]};
  assign perm     = perm_sel(ord);
  assign inv_mask = inv_sel(inv);

  assign src[0] = fixed_data[FIX_W-1:WORD_W];
  assign src[1] = fixed_data[WORD_W-1:0];
  assign src[2] = {dig[4], dig[5], dig[6], dig[7], dig[8]};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      w[k] = src[perm[k]] ^ {WORD_W{inv_mask[k]}};
    end
    // bit k of words 0,1,2 lands at 3k+2, 3k+1, 3k
    for (int k = 0; k < WORD_W; k++) begin
      data[3*k+2] = w[0][k];
      data[3*k+1] = w[1][k];
      data[3*k]   = w[2][k];
    end
  end

  assign packet = {HDR_NIB, 1'b0, packet_flag, 2'b00, ord, inv, data};

endmodule

>>> sv/rolling_code_packet_encoder.sv
// Top level of the rolling-code packet encoder: counter reversal, base-3 pipe,
// packet assembly. Depends on rcpe_pkg, rcpe_if, rcpe_digit_stage, rcpe_half_builder.
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    counter_value[27:0] button_code[7:0] serial_number[31:0]
//  out_ch   out  valid/ready    first_packet[45:0] second_packet[45:0]
//
// One word per cycle while out_ch does not stall; six conversion stages of three
// base-3 digits each (compare/subtract chain per stage), then the packet register.
// Reset (rst_n low, synchronous) empties the pipe; payload registers are not reset.
// Each stage holds its word until the next one takes it, so a stall on out_ch
// fills bubbles first and then backs up to in_ch.ready without loss.
module rolling_code_packet_encoder import rcpe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rcpe_in_if.sink     in_ch,
  rcpe_out_if.source  out_ch
);

  logic   stg_valid [NUM_STG+1];
  logic   stg_ready [NUM_STG+1];
  stage_t stg_data  [NUM_STG+1];

  logic [CNT_W-1:0] roll;
  always_comb begin
    for (int i = 0; i < CNT_W; i++) begin
      roll[CNT_W-1-i] = in_ch.counter_value[i];
    end
  end

  assign stg_valid[0]       = in_ch.valid;
  assign in_ch.ready        = stg_ready[0];
  assign stg_data[0].rem    = roll;
  assign stg_data[0].digits = '0;
  assign stg_data[0].button = in_ch.button_code;
  assign stg_data[0].serial = in_ch.serial_number;

  for (genvar s = 0; s < NUM_STG; s++) begin : g_stg
    rcpe_digit_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (STG_W'(s)),
      .in_valid  (stg_valid[s]),
      .in_ready  (stg_ready[s]),
      .in_data   (stg_data[s]),
      .out_valid (stg_valid[s+1]),
      .out_ready (stg_ready[s+1]),
      .out_data  (stg_data[s+1])
    );
  end

  // deal digits to the halves
  stage_t    last;
  half_dig_t h1;
  half_dig_t h2;
  assign last = stg_data[NUM_STG];

  always_comb begin
    h2[8] = last.digits[0];
    h1[8] = last.digits[1];
    for (int i = 0; i < 4; i++) begin
      h2[4+i] = last.digits[2+i];
      h1[4+i] = last.digits[6+i];
      h2[i]   = last.digits[10+i];
      h1[i]   = last.digits[14+i];
    end
  end

  logic [PKT_W-1:0] pkt1;
  logic [PKT_W-1:0] pkt2;

  // first half: button code above the top 12 serial bits
  rcpe_half_builder u_half1 (
    .dig         (h1),
    .fixed_data  ({last.button, last.serial[SER_W-1:FIX_W]}),
    .packet_flag (FLAG_FIRST),
    .packet      (pkt1)
  );

  rcpe_half_builder u_half2 (
    .dig         (h2),
    .fixed_data  (last.serial[FIX_W-1:0]),
    .packet_flag (FLAG_SECOND),
    .packet      (pkt2)
  );

  logic             out_valid_r;
  logic [PKT_W-1:0] first_r;
  logic [PKT_W-1:0] second_r;

  assign stg_ready[NUM_STG] = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_ready[NUM_STG]) begin
      out_valid_r <= stg_valid[NUM_STG];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_ready[NUM_STG] && stg_valid[NUM_STG]) begin
      first_r  <= pkt1;
      second_r <= pkt2;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.first_packet  = first_r;
  assign out_ch.second_packet = second_r;

endmodule

>>> sv/rcpe_checker.sv
// Port-level checks for rolling_code_packet_encoder, attached by bind.
// Depends on rcpe_pkg for widths.
module rcpe_checker import rcpe_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PKT_W-1:0] first_packet,
  input logic [PKT_W-1:0] second_packet
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(first_packet) && $stable(second_packet))
    else $error("result word changed while stalled");

  // with nothing waiting at the output the whole pipe can move
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output empty");

  // order and invert nibbles are built from base-3 digits only
  a_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> first_packet[37:36] != 2'b11 && first_packet[35:34] != 2'b11 &&
                  first_packet[33:32] != 2'b11 && first_packet[31:30] != 2'b11 &&
                  second_packet[37:36] != 2'b11 && second_packet[35:34] != 2'b11 &&
                  second_packet[33:32] != 2'b11 && second_packet[31:30] != 2'b11)
    else $error("digit out of range in packet nibble");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rolling_code_packet_encoder rcpe_checker u_rcpe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .first_packet  (out_ch.first_packet),
  .second_packet (out_ch.second_packet)
);
